>>> hdl/msgenc_pkg.sv
// shared types and constants for the messagepack scalar/header encoder
package msgenc_pkg;

  // value kinds carried in cmd
  localparam logic [2:0] CMD_NIL   = 3'd0;
  localparam logic [2:0] CMD_BOOL  = 3'd1;
  localparam logic [2:0] CMD_INT   = 3'd2;
  localparam logic [2:0] CMD_FLOAT = 3'd3;
  localparam logic [2:0] CMD_STR   = 3'd4;
  localparam logic [2:0] CMD_BIN   = 3'd5;
  localparam logic [2:0] CMD_ARRAY = 3'd6;
  localparam logic [2:0] CMD_MAP   = 3'd7;

  // format bytes
  localparam logic [7:0] FMT_FIXMAP   = 8'h80;
  localparam logic [7:0] FMT_FIXARRAY = 8'h90;
  localparam logic [7:0] FMT_FIXSTR   = 8'hA0;
  localparam logic [7:0] FMT_NIL      = 8'hC0;
  localparam logic [7:0] FMT_FALSE    = 8'hC2;
  localparam logic [7:0] FMT_TRUE     = 8'hC3;
  localparam logic [7:0] FMT_BIN8     = 8'hC4;
  localparam logic [7:0] FMT_BIN16    = 8'hC5;
  localparam logic [7:0] FMT_BIN32    = 8'hC6;
  localparam logic [7:0] FMT_FLOAT64  = 8'hCB;
  localparam logic [7:0] FMT_UINT8    = 8'hCC;
  localparam logic [7:0] FMT_UINT16   = 8'hCD;
  localparam logic [7:0] FMT_UINT32   = 8'hCE;
  localparam logic [7:0] FMT_UINT64   = 8'hCF;
  localparam logic [7:0] FMT_INT8     = 8'hD0;
  localparam logic [7:0] FMT_INT16    = 8'hD1;
  localparam logic [7:0] FMT_INT32    = 8'hD2;
  localparam logic [7:0] FMT_INT64    = 8'hD3;
  localparam logic [7:0] FMT_STR8     = 8'hD9;
  localparam logic [7:0] FMT_STR16    = 8'hDA;
  localparam logic [7:0] FMT_STR32    = 8'hDB;
  localparam logic [7:0] FMT_ARRAY16  = 8'hDC;
  localparam logic [7:0] FMT_ARRAY32  = 8'hDD;
  localparam logic [7:0] FMT_MAP16    = 8'hDE;
  localparam logic [7:0] FMT_MAP32    = 8'hDF;

  localparam int FIFO_DEPTH = 2;

  // one classified item: format byte, trailing bytes left-aligned, count of trailing bytes, error flag
  typedef struct packed {
    logic [7:0]  prefix;
    logic [63:0] payload;
    logic [3:0]  nbytes;
    logic        err;
  } desc_t;

endpackage

>>> hdl/msgenc_front.sv
// front end: accepts input transactions and classifies them into format descriptors
module msgenc_front import msgenc_pkg::*; (
  input  logic        s_valid,
  output logic        s_ready,
  input  logic [2:0]  cmd,
  input  logic [63:0] value,
  input  logic        q_full,
  output logic        q_push,
  output desc_t       q_data
);

  logic signed [63:0] sv;
  logic               too_long;
  logic               lt_10, lt_20, lt_80, lt_100, lt_10000;
  logic [7:0]         pfx;
  logic [3:0]         nb;
  logic               err;

  assign sv       = value;
  assign too_long = value[63] || (value[62:32] != '0);
  assign lt_10    = value[63:4]  == '0;
  assign lt_20    = value[63:5]  == '0;
  assign lt_80    = value[63:7]  == '0;
  assign lt_100   = value[63:8]  == '0;
  assign lt_10000 = value[63:16] == '0;

  always_comb begin
    pfx = FMT_NIL;
    nb  = 4'd0;
    err = 1'b0;
    case (cmd)
      CMD_NIL: begin
        pfx = FMT_NIL;
      end
      CMD_BOOL: begin
        pfx = value[0] ? FMT_TRUE : FMT_FALSE;
      end
      CMD_INT: begin
        if (value[63]) begin
          if (sv >= -64'sd32) begin
            pfx = value[7:0];
          end else if (sv >= -64'sd128) begin
            pfx = FMT_INT8;  nb = 4'd1;
          end else if (sv >= -64'sd32768) begin
            pfx = FMT_INT16; nb = 4'd2;
          end else if (sv >= -64'sd2147483648) begin
            pfx = FMT_INT32; nb = 4'd4;
          end else begin
            pfx = FMT_INT64; nb = 4'd8;
          end
        end else if (lt_80) begin
          pfx = value[7:0];
        end else if (lt_100) begin
          pfx = FMT_UINT8;  nb = 4'd1;
        end else if (lt_10000) begin
          pfx = FMT_UINT16; nb = 4'd2;
        end else if (!too_long) begin
          pfx = FMT_UINT32; nb = 4'd4;
        end else begin
          pfx = FMT_UINT64; nb = 4'd8;
        end
      end
      CMD_FLOAT: begin
        pfx = FMT_FLOAT64; nb = 4'd8;
      end
      CMD_STR: begin
        if (too_long) begin
          pfx = 8'h00; err = 1'b1;
        end else if (lt_20) begin
          pfx = FMT_FIXSTR | {3'b000, value[4:0]};
        end else if (lt_100) begin
          pfx = FMT_STR8;  nb = 4'd1;
        end else if (lt_10000) begin
          pfx = FMT_STR16; nb = 4'd2;
        end else begin
          pfx = FMT_STR32; nb = 4'd4;
        end
      end
      CMD_BIN: begin
        if (too_long) begin
          pfx = 8'h00; err = 1'b1;
        end else if (lt_100) begin
          pfx = FMT_BIN8;  nb = 4'd1;
        end else if (lt_10000) begin
          pfx = FMT_BIN16; nb = 4'd2;
        end else begin
          pfx = FMT_BIN32; nb = 4'd4;
        end
      end
      CMD_ARRAY: begin
        if (too_long) begin
          pfx = 8'h00; err = 1'b1;
        end else if (lt_10) begin
          pfx = FMT_FIXARRAY | {4'b0000, value[3:0]};
        end else if (lt_10000) begin
          pfx = FMT_ARRAY16; nb = 4'd2;
        end else begin
          pfx = FMT_ARRAY32; nb = 4'd4;
        end
      end
      CMD_MAP: begin
        if (too_long) begin
          pfx = 8'h00; err = 1'b1;
        end else if (lt_10) begin
          pfx = FMT_FIXMAP | {4'b0000, value[3:0]};
        end else if (lt_10000) begin
          pfx = FMT_MAP16; nb = 4'd2;
        end else begin
          pfx = FMT_MAP32; nb = 4'd4;
        end
      end
      default: begin
        pfx = FMT_NIL;
      end
    endcase
  end

  always_comb begin
    q_data.prefix = pfx;
    q_data.nbytes = nb;
    q_data.err    = err;
    // trailing bytes go out from the top of the word
    case (nb)
      4'd1:    q_data.payload = {value[7:0],  56'd0};
      4'd2:    q_data.payload = {value[15:0], 48'd0};
      4'd4:    q_data.payload = {value[31:0], 32'd0};
      4'd8:    q_data.payload = value;
      default: q_data.payload = 64'd0;
    endcase
  end

  assign s_ready = !q_full;
  assign q_push  = s_valid && !q_full;

endmodule

>>> hdl/msgenc_fifo.sv
// descriptor queue between the classifier and the byte serializer
module msgenc_fifo import msgenc_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output desc_t pop_data,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t          slots [DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [CW-1:0]  count;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/msgenc_back.sv
// back end: serializes one descriptor into bytes behind an output register
module msgenc_back import msgenc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  desc_t      q_data,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       m_valid,
  input  logic       m_ready,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       error
);

  logic [63:0] shreg;
  logic [3:0]  remain;
  logic        adv;

  assign adv   = !m_valid || m_ready;
  assign q_pop = adv && (remain == 4'd0) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      remain  <= 4'd0;
    end else if (adv) begin
      if (remain != 4'd0) begin
        m_valid <= 1'b1;
        remain  <= remain - 4'd1;
      end else if (!q_empty) begin
        m_valid <= 1'b1;
        remain  <= q_data.nbytes;
      end else begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (remain != 4'd0) begin
        out_byte <= shreg[63:56];
        shreg    <= {shreg[55:0], 8'd0};
        last     <= remain == 4'd1;
        error    <= 1'b0;
      end else if (!q_empty) begin
        out_byte <= q_data.prefix;
        shreg    <= q_data.payload;
        last     <= q_data.nbytes == 4'd0;
        error    <= q_data.err;
      end
    end
  end

endmodule

>>> hdl/msgpack_scalar_header_encoder_core.sv
// top level of the messagepack scalar and header encoder
//
//  channel  | direction | tdata                          | tlast      | tuser
//  ---------+-----------+--------------------------------+------------+-------
//  s_axis   | in        | [2:0] cmd, [66:3] value, pad   | -          | -
//  m_axis   | out       | [7:0] out_byte                 | last byte  | [0] error
//
//  each value leaves as 1 to 9 byte transactions, one per cycle unless stalled: a
//  format byte and then 0, 1, 2, 4 or 8 trailing bytes; the serializer sets the rate
//  an input transaction is accepted whenever the descriptor queue has room, even while
//  the serializer is busy or the output is stalled; its value passes through the queue
//  and then the output register before its first byte is valid
//  rst is synchronous, active high; clears the queue and the output valid
//  a stalled output holds its byte and stops the serializer; the classifier keeps
//  filling the queue until it is full
module msgpack_scalar_header_encoder_core import msgenc_pkg::*; #(
  parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [2:0] cmd, [66:3] value, [71:67] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // [0] error
);

  desc_t push_data;
  desc_t pop_data;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  // classify into format byte and trailing byte count
  msgenc_front u_front (
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .cmd     (s_axis_tdata[2:0]),
    .value   (s_axis_tdata[66:3]),
    .q_full  (full),
    .q_push  (push),
    .q_data  (push_data)
  );

  // decouples classification from serialization
  msgenc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // one byte per cycle while the output is not stalled, most significant first
  msgenc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (pop_data),
    .q_empty  (empty),
    .q_pop    (pop),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .out_byte (m_axis_tdata),
    .last     (m_axis_tlast),
    .error    (m_axis_tuser[0])
  );

endmodule

>>> hdl/msgenc_checker.sv
// port-level checks for the encoder, bound to the top level
module msgenc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [0:0]  m_axis_tuser
);

  // a held output transaction keeps its byte and markers
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // an error result is a single zero byte that closes its value
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("error result not a lone zero byte");

  // reset empties the output register
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // the queue can only fill up behind a pending output byte
  a_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with output idle");

endmodule

bind msgpack_scalar_header_encoder_core msgenc_checker u_msgenc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
